// ===== rtl/core/dtp_pkg.sv =====
// Shared types, phase codes, unit codes and limits for the duration text parser.
`default_nettype none

package dtp_pkg;

    // Scan phase codes
    localparam logic [2:0] PH_LEAD   = 3'd0;  // skipping space and tab
    localparam logic [2:0] PH_WS     = 3'd1;  // skipping any blank before the sign
    localparam logic [2:0] PH_SIGN   = 3'd2;  // sign seen, digit expected
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_GAP    = 3'd4;  // spaces and tabs between number and unit
    localparam logic [2:0] PH_UNIT   = 3'd5;
    localparam logic [2:0] PH_ERR    = 3'd6;

    // Unit scale selectors
    localparam logic [1:0] SCALE_NONE = 2'd0;
    localparam logic [1:0] SCALE_MIN  = 2'd1;
    localparam logic [1:0] SCALE_HOUR = 2'd2;
    localparam logic [1:0] SCALE_DAY  = 2'd3;

    localparam int          UNIT_DEPTH   = 7;
    localparam logic [20:0] LIMIT        = 21'd1000000;
    localparam logic [20:0] SAT_VALUE    = 21'd1000001;
    localparam logic [10:0] HOUR_MINUTES = 11'd60;
    localparam logic [10:0] DAY_MINUTES  = 11'd1440;
    // Largest value that still scales to at most the limit
    localparam logic [20:0] MAX_HOURS    = 21'd16666;
    localparam logic [20:0] MAX_DAYS     = 21'd694;
    localparam logic [20:0] MINUTES_ERR  = '1;

    typedef logic [UNIT_DEPTH-1:0][7:0] letters_t;

    // Parse state of one string
    typedef struct packed {
        logic [2:0]  phase;
        logic [20:0] acc;
        logic        neg;
        letters_t    letters;
        logic [3:0]  len;
    } dtp_str_t;

    // Match the lowered unit letters against the known unit words
    function automatic logic [1:0] unit_scale(input letters_t l, input logic [3:0] n);
        logic [55:0] w;
        logic [1:0]  s;
        begin
            w = {l[0], l[1], l[2], l[3], l[4], l[5], l[6]};
            s = SCALE_NONE;
            case (n)
                4'd1:
                begin
                    if (w[55:48] == "m")      s = SCALE_MIN;
                    else if (w[55:48] == "h") s = SCALE_HOUR;
                    else if (w[55:48] == "d") s = SCALE_DAY;
                end
                4'd2:
                begin
                    if (w[55:40] == "hr") s = SCALE_HOUR;
                end
                4'd3:
                begin
                    if (w[55:32] == "min")      s = SCALE_MIN;
                    else if (w[55:32] == "hrs") s = SCALE_HOUR;
                    else if (w[55:32] == "day") s = SCALE_DAY;
                end
                4'd4:
                begin
                    if (w[55:24] == "mins")      s = SCALE_MIN;
                    else if (w[55:24] == "hour") s = SCALE_HOUR;
                    else if (w[55:24] == "days") s = SCALE_DAY;
                end
                4'd5:
                begin
                    if (w[55:16] == "hours") s = SCALE_HOUR;
                end
                4'd6:
                begin
                    if (w[55:8] == "minute") s = SCALE_MIN;
                end
                4'd7:
                begin
                    if (w == "minutes") s = SCALE_MIN;
                end
                default: s = SCALE_NONE;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtp_scan.sv =====
// Character scanner: holds the parse state of the current string.
`default_nettype none

module dtp_scan
    import dtp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire logic [7:0] char_code,
    input  wire logic     last,
    output dtp_str_t      snap        // state after this character
);

    dtp_str_t st_reg;
    dtp_str_t st_next;
    logic     term_reg;
    logic     term_next;

    logic        is_digit;
    logic        is_sp_tab;
    logic        is_blank;
    logic        is_sign;
    logic [3:0]  digit;
    logic [7:0]  lower;
    logic [23:0] acc_x10;

    // Character classes
    always_comb
    begin
        is_digit  = char_code inside {[8'h30:8'h39]};
        is_sp_tab = char_code == 8'h20 || char_code == 8'h09;
        is_blank  = char_code == 8'h20 || (char_code inside {[8'h09:8'h0D]});
        is_sign   = char_code == 8'h2B || char_code == 8'h2D;
        digit     = 4'(char_code - 8'h30);
        lower     = (char_code inside {[8'h41:8'h5A]}) ? (char_code | 8'h20) : char_code;
        acc_x10   = {st_reg.acc, 3'b000} + {2'b00, st_reg.acc, 1'b0} + {20'd0, digit};
    end

    // Next parse state
    always_comb
    begin
        logic take_unit;
        logic start_num;
        take_unit = 1'b0;
        start_num = 1'b0;
        st_next   = st_reg;
        term_next = term_reg;
        if (!term_reg)
        begin
            if (char_code == 8'h00)
            begin
                term_next = 1'b1;
            end
            else
            begin
                case (st_reg.phase)
                    PH_LEAD:
                    begin
                        if (is_sp_tab)      ;
                        else if (is_blank)  st_next.phase = PH_WS;
                        else                start_num = 1'b1;
                    end
                    PH_WS:
                    begin
                        if (!is_blank) start_num = 1'b1;
                    end
                    PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            st_next.acc   = {17'd0, digit};
                            st_next.phase = PH_DIGITS;
                        end
                        else
                        begin
                            st_next.phase = PH_ERR;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            st_next.acc = (acc_x10 > {3'd0, LIMIT}) ? SAT_VALUE : acc_x10[20:0];
                        end
                        else if (is_sp_tab)
                        begin
                            st_next.phase = PH_GAP;
                        end
                        else
                        begin
                            take_unit = 1'b1;
                        end
                    end
                    PH_GAP:
                    begin
                        if (!is_sp_tab) take_unit = 1'b1;
                    end
                    PH_UNIT: take_unit = 1'b1;
                    default: st_next.phase = PH_ERR;
                endcase

                // Sign or first digit after the leading blanks
                if (start_num)
                begin
                    if (is_sign)
                    begin
                        st_next.neg   = char_code == 8'h2D;
                        st_next.phase = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        st_next.acc   = {17'd0, digit};
                        st_next.phase = PH_DIGITS;
                    end
                    else
                    begin
                        st_next.phase = PH_ERR;
                    end
                end

                // Unit letter store, length saturates one past the depth
                if (take_unit)
                begin
                    st_next.phase = PH_UNIT;
                    if (st_reg.len < 4'(UNIT_DEPTH))
                        st_next.letters[st_reg.len[2:0]] = lower;
                    if (st_reg.len <= 4'(UNIT_DEPTH))
                        st_next.len = st_reg.len + 4'd1;
                end
            end
        end
    end

    assign snap = st_next;

    // State register, cleared after the last character of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            term_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                st_reg   <= '0;
                term_reg <= 1'b0;
            end
            else
            begin
                st_reg   <= st_next;
                term_reg <= term_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A finished string leaves a clean state behind
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> st_reg.phase == PH_LEAD && st_reg.len == 4'd0 && !term_reg)
        else $error("parse state not cleared after last character");

    // Unit length never passes one beyond the letter store
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.len <= 4'(UNIT_DEPTH + 1))
        else $error("unit length out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/dtp_finish.sv =====
// End-of-string stage: unit match, scaling, range check and result register.
`default_nettype none

module dtp_finish
    import dtp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,        // last character taken this cycle
    input  wire dtp_str_t snap,
    output logic       room,        // a new string end can be taken
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       ok,
    output logic [20:0] minutes
);

    logic       snap_v_reg;
    logic       snap_v_next;
    dtp_str_t   snap_reg;
    logic       out_v_reg;
    logic       out_v_next;
    logic       ok_reg;
    logic       ok_next;
    logic [20:0] min_reg;
    logic [20:0] min_next;

    logic        advance;
    logic [1:0]  sel;
    logic [31:0] product;
    logic        fits;

    assign advance = snap_v_reg && (!out_v_reg || out_ready);
    assign room    = !snap_v_reg || !out_v_reg || out_ready;

    // Scale and check the finished string
    always_comb
    begin
        sel = unit_scale(snap_reg.letters, snap_reg.len);
        case (sel)
            SCALE_MIN:
            begin
                product = {11'd0, snap_reg.acc};
                fits    = 1'b1;
            end
            SCALE_HOUR:
            begin
                product = 32'(snap_reg.acc) * 32'(HOUR_MINUTES);
                fits    = snap_reg.acc <= MAX_HOURS;
            end
            SCALE_DAY:
            begin
                product = 32'(snap_reg.acc) * 32'(DAY_MINUTES);
                fits    = snap_reg.acc <= MAX_DAYS;
            end
            default:
            begin
                product = 32'd0;
                fits    = 1'b0;
            end
        endcase
        ok_next = snap_reg.phase == PH_UNIT && !snap_reg.neg && snap_reg.acc != 21'd0
                  && snap_reg.acc <= LIMIT && fits;
        min_next = ok_next ? product[20:0] : MINUTES_ERR;
    end

    // Valid flags of both stages
    always_comb
    begin
        snap_v_next = load || (snap_v_reg && !advance);
        if (advance)
            out_v_next = 1'b1;
        else if (out_ready)
            out_v_next = 1'b0;
        else
            out_v_next = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            snap_v_reg <= snap_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            snap_reg <= snap;
        if (advance)
        begin
            ok_reg  <= ok_next;
            min_reg <= min_next;
        end
    end

    assign out_valid = out_v_reg;
    assign ok        = ok_reg;
    assign minutes   = min_reg;

`ifndef NO_ASSERTIONS
    // A good result lies in the legal range
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && ok_reg |-> min_reg != 21'd0 && min_reg <= LIMIT)
        else $error("valid duration out of range");

    // An error result carries all ones
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && !ok_reg |-> min_reg == MINUTES_ERR)
        else $error("error result without error code");

    // Both stages full and stalled: no further string end may enter
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        snap_v_reg && out_v_reg && !out_ready |-> !room && !load)
        else $error("string end taken with no room");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/duration_text_parser_core.sv =====
// Top level of the duration text parser: stream ports, scanner and end stage.
//
// Use: a duration string such as "30m" or "2 Hours" enters one character per
// transaction on the s_axis channel, with s_axis_tlast on its final character.
// A character code of zero ends the string early; characters after it up to
// the tlast transaction are ignored. Each tlast transaction gives exactly one
// result transaction on m_axis: ok and the duration in minutes, or ok = 0 with
// minutes all ones on any parse error. Nothing comes out for other characters.
// Throughput: one character per cycle while s_axis_tready is high.
// Path: a finished string passes the end-of-string register and then the result
// register, whose valid flag drives m_axis_tvalid.
// Stall: while m_axis_tready is low, one more finished string is held in the
// end-of-string register; after that s_axis_tready falls until the result is
// taken. s_axis_tready follows m_axis_tready through one gate.
// Reset: rst_n low clears the parse state and both valid flags; the block
// accepts characters as soon as reset is released.
`default_nettype none

module duration_text_parser_core
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // [0] ok, [21:1] minutes, [23:22] zero
);

    logic        accept;
    dtp_str_t    snap;
    logic        room;
    logic        ok;
    logic [20:0] minutes;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    dtp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_axis_tdata),
        .last      (s_axis_tlast),
        .snap      (snap)
    );

    dtp_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && s_axis_tlast),
        .snap      (snap),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ok        (ok),
        .minutes   (minutes)
    );

    assign m_axis_tdata = {2'b00, minutes, ok};

endmodule

`default_nettype wire

// ===== bench/duration_checker.sv =====
// Duration parser checker: watches both stream channels, predicts each result and compares.
`default_nettype none

module duration_checker
    import dtp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [23:0] m_axis_tdata,   // [0] ok, [21:1] minutes, [23:22] zero
    output int               errors,
    output int               awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        ok;
        logic [20:0] minutes;
    } duration_t;

    localparam logic [7:0] TERMINATOR = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_MINUS   = "-";

    duration_t   pending_durations[$];

    // Own copy of the per-string parse state
    logic [2:0]  phase;
    int unsigned acc_value;
    logic        negative;
    logic [7:0]  letters [0:UNIT_DEPTH-1];
    int unsigned letter_count;
    logic        string_done;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_sp_tab(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task clear_string();
        phase        = PH_LEAD;
        acc_value    = 0;
        negative     = 1'b0;
        letter_count = 0;
        string_done  = 1'b0;
        for (int i = 0; i < UNIT_DEPTH; i++)
            letters[i] = 8'h00;
    endtask

    // Unit text is kept lowered; the count stops one past the depth
    task keep_letter(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (lc >= "A" && lc <= "Z")
            lc = lc + 8'd32;
        if (letter_count < UNIT_DEPTH)
            letters[letter_count] = lc;
        if (letter_count <= UNIT_DEPTH)
            letter_count++;
    endtask

    task begin_number(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            negative = (c == CH_MINUS);
            phase    = PH_SIGN;
        end
        else if (is_digit(c))
        begin
            acc_value = 32'(c - "0");
            phase     = PH_DIGITS;
        end
        else
            phase = PH_ERR;
    endtask

    task scan_char(input logic [7:0] c);
        int unsigned grown;
        case (phase)
            PH_LEAD:
            begin
                if (is_sp_tab(c))
                    ;
                else if (is_blank(c))
                    phase = PH_WS;
                else
                    begin_number(c);
            end
            PH_WS:
            begin
                if (!is_blank(c))
                    begin_number(c);
            end
            PH_SIGN:
            begin
                if (is_digit(c))
                begin
                    acc_value = 32'(c - "0");
                    phase     = PH_DIGITS;
                end
                else
                    phase = PH_ERR;
            end
            PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    grown     = acc_value * 10 + 32'(c - "0");
                    acc_value = (grown > 32'(LIMIT)) ? 32'(SAT_VALUE) : grown;
                end
                else if (is_sp_tab(c))
                    phase = PH_GAP;
                else
                begin
                    keep_letter(c);
                    phase = PH_UNIT;
                end
            end
            PH_GAP:
            begin
                if (!is_sp_tab(c))
                begin
                    keep_letter(c);
                    phase = PH_UNIT;
                end
            end
            PH_UNIT: keep_letter(c);
            default: phase = PH_ERR;
        endcase
    endtask

    // Result of the string parsed so far
    function automatic duration_t duration_of();
        string       word;
        int unsigned scale;
        int unsigned product;
        duration_t   r;
        r.ok      = 1'b0;
        r.minutes = MINUTES_ERR;
        scale     = 0;
        word      = "";
        if (phase != PH_UNIT || negative || acc_value == 0 || acc_value > 32'(LIMIT))
            return r;
        // a unit longer than the store can never match
        if (letter_count <= UNIT_DEPTH)
        begin
            for (int i = 0; i < letter_count; i++)
                word = $sformatf("%s%c", word, letters[i]);
            if (word == "m" || word == "min" || word == "mins" || word == "minute" ||
                word == "minutes")
                scale = 1;
            else if (word == "h" || word == "hr" || word == "hrs" || word == "hour" ||
                     word == "hours")
                scale = 32'(HOUR_MINUTES);
            else if (word == "d" || word == "day" || word == "days")
                scale = 32'(DAY_MINUTES);
        end
        if (scale == 0)
            return r;
        product = acc_value * scale;
        if (product > 32'(LIMIT))
            return r;
        r.ok      = 1'b1;
        r.minutes = product[20:0];
        return r;
    endfunction

    // Compare results first, then fold in the character of this edge
    always @(posedge clk or negedge rst_n)
    begin
        duration_t want;
        if (!rst_n)
        begin
            clear_string();
            pending_durations.delete();
            errors   = 0;
            awaiting = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_durations.size() == 0)
                begin
                    $display("%0t: result with none outstanding, actual ok=%0d minutes=%0d",
                             $time, m_axis_tdata[0], $signed(m_axis_tdata[21:1]));
                    errors++;
                end
                else
                begin
                    want = pending_durations.pop_front();
                    if (m_axis_tdata[0] !== want.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0d, actual %0d",
                                 $time, want.ok, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[21:1] !== want.minutes)
                    begin
                        $display("%0t: minutes mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.minutes), $signed(m_axis_tdata[21:1]));
                        errors++;
                    end
                    if (m_axis_tdata[23:22] !== 2'b00)
                    begin
                        $display("%0t: fill bits mismatch, expected 00, actual %b",
                                 $time, m_axis_tdata[23:22]);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (!string_done)
                begin
                    if (s_axis_tdata == TERMINATOR)
                        string_done = 1'b1;
                    else
                        scan_char(s_axis_tdata);
                end
                if (s_axis_tlast)
                begin
                    pending_durations.push_back(duration_of());
                    clear_string();
                end
            end
            awaiting = pending_durations.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench top for the duration text parser: clock, reset, character stimulus and verdict.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = "0";

    localparam int RANDOM_CHARS = 850;
    localparam int HOLD_AFTER   = 300;   // characters sent before the long output stall
    localparam int HOLD_CYCLES  = 160;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [23:0] m_axis_tdata;   // [0] ok, [21:1] minutes, [23:22] zero

    int          errors;
    int          awaiting;
    int          sent_count;

    char_item_t  text_q[$];

    // values either side of the limits of each scale
    int    boundary_values[7] = '{0, 694, 695, 16666, 16667, 1000000, 1000001};
    string unit_words[20] = '{"m", "min", "mins", "minute", "minutes",
                              "h", "hr", "hrs", "hour", "hours",
                              "d", "day", "days",
                              "mi", "hou", "minutess", "x", "dayss", "hrs s", "minutesx"};

    duration_text_parser_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    duration_checker duration_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .awaiting      (awaiting)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task put_char(input logic [7:0] c, input logic l);
        char_item_t item;
        item.code = c;
        item.last = l;
        text_q.push_back(item);
    endtask

    task put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], 1'b0);
    endtask

    // Mark the newest character as the end of its string
    task close_string();
        char_item_t item;
        item = text_q.pop_back();
        item.last = 1'b1;
        text_q.push_back(item);
    endtask

    task put_line(input string s);
        put_text(s);
        close_string();
    endtask

    task put_sp_tab();
        put_char($urandom_range(1) ? CH_SPACE : CH_TAB, 1'b0);
    endtask

    // One random string: mostly well-formed durations, the rest noise or broken
    task make_random_duration();
        int         pick;
        int         v;
        string      digits;
        string      word;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            repeat ($urandom_range(1, 10))
                put_char(8'($urandom_range(255)), 1'b0);
            close_string();
            return;
        end
        repeat ($urandom_range(0, 2))
            put_sp_tab();
        if ($urandom_range(4) == 0)
        begin
            // a line-ending blank moves the scan into the wider blank skip
            put_char(CH_TAB + 8'($urandom_range(1, 4)), 1'b0);
            repeat ($urandom_range(0, 2))
                put_char($urandom_range(5) == 0 ? CH_SPACE
                                                : CH_TAB + 8'($urandom_range(4)), 1'b0);
        end
        pick = $urandom_range(19);
        if (pick < 2)
            put_char("+", 1'b0);
        else if (pick == 2)
            put_char("-", 1'b0);
        if ($urandom_range(19) == 0)
            put_char($urandom_range(1) ? CH_SPACE : "k", 1'b0);
        if ($urandom_range(19) == 0)
        begin
            // more digits than the accumulator can hold
            repeat ($urandom_range(8, 12))
                put_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
        end
        else
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: v = $urandom_range(1, 999);
                5:             v = $urandom_range(1, 20000);
                6:             v = boundary_values[$urandom_range(6)];
                7:             v = $urandom_range(1, 1000000);
                8:             v = $urandom_range(1, 9999999);
                default:       v = $urandom_range(1, 60);
            endcase
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3))
                    put_char(CH_ZERO, 1'b0);
            digits = $sformatf("%0d", v);
            put_text(digits);
        end
        if ($urandom_range(9) < 4)
            repeat ($urandom_range(1, 2))
                put_sp_tab();
        if ($urandom_range(19) != 0)
        begin
            word = ($urandom_range(99) < 85) ? unit_words[$urandom_range(12)]
                                             : unit_words[$urandom_range(13, 19)];
            for (int i = 0; i < word.len(); i++)
            begin
                c = word[i];
                if (c >= "a" && c <= "z" && $urandom_range(3) == 0)
                    c = c - 8'd32;
                put_char(c, 1'b0);
            end
        end
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            put_char(CH_NUL, 1'b0);
            repeat ($urandom_range(0, 3))
                put_char(8'($urandom_range(255)), 1'b0);
        end
        else if (pick < 12)
            put_char(8'($urandom_range(1, 255)), 1'b0);
        // a string with no characters still needs one to carry the end mark
        if (text_q.size() == 0 || text_q[text_q.size() - 1].last)
            put_char(CH_SPACE, 1'b0);
        close_string();
    endtask

    task build_directed();
        put_line("1m");
        put_line("1000000m");
        put_line("1000001m");
        put_line("16666 hours");
        put_line("16667h");
        put_line("694 days");
        put_line("695d");
        put_line("0m");
        put_line("-5m");
        put_line("+5MIN");
        put_char(CH_SPACE, 1'b0);
        put_char(CH_TAB, 1'b0);
        put_line(" 7 Hours");
        put_char(CH_LF, 1'b0);
        put_char(CH_CR, 1'b0);
        put_char(CH_VT, 1'b0);
        put_char(CH_FF, 1'b0);
        put_line("+12hr");
        put_line("+");
        put_line("   ");
        put_line("42");
        put_line("42 \t");
        put_line("5minutesx");
        put_line("5 minutes ");
        put_line("99999999999m");
        put_text("5m");
        put_char(CH_NUL, 1'b0);
        put_line("zz");
        put_text("9");
        put_char(CH_NUL, 1'b0);
        put_line("m");
        put_char(CH_NUL, 1'b1);
        put_line("+ 5m");
        put_line("12xyz");
        put_line("3\tDaYs");
        put_char(8'hFF, 1'b0);
        put_line("3m");
    endtask

    // Reset, character stimulus and verdict
    initial
    begin
        int wait_cycles;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        sent_count    = 0;
        build_directed();
        while (text_q.size() < RANDOM_CHARS)
            make_random_duration();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        foreach (text_q[i])
        begin
            // idle-free stretch in the middle of the run
            while (!(i >= 500 && i < 650) && $urandom_range(99) < 31)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_q[i].code;
            s_axis_tlast  <= text_q[i].last;
            do
                @(posedge clk);
            while (!s_axis_tready);
            sent_count++;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        // let the checker count the final string end first
        @(posedge clk);
        wait_cycles = 0;
        while (awaiting != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (errors == 0 && awaiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, one long hold-off, a stall-free stretch, then random stalls again
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        while (sent_count < HOLD_AFTER)
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(99) >= 31);
        end
        repeat (HOLD_CYCLES)
        begin
            @(posedge clk);
            m_axis_tready <= 1'b0;
        end
        repeat (250)
        begin
            @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(99) >= 31);
        end
    end

    initial
    begin
        #2400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
